// ===== rtl/core/mats_pkg.sv =====
// Package for the moving-average trade signal unit.
// Field widths, register reset value and the signal codes.
// No dependencies.
package mats_pkg;

    // Field widths
    localparam int PRICE_W = 32;
    localparam int AVG_W   = 32;
    localparam int CNT_W   = 6;

    // Window length after reset
    localparam logic [CNT_W-1:0] WINDOW_RESET = 6'd20;

    // Trade signal codes
    typedef enum logic [1:0] {
        SIG_HOLD = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } sig_t;

endpackage

// ===== rtl/core/mats_if.sv =====
// Valid/ready channel interfaces for the moving-average trade signal unit.
// Depends on mats_pkg for field widths and the signal code type.
interface mats_sample_if;
    logic                          valid;
    logic                          ready;
    logic [mats_pkg::PRICE_W-1:0]  price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

interface mats_result_if;
    logic                          valid;
    logic                          ready;
    logic [mats_pkg::AVG_W-1:0]    average;
    mats_pkg::sig_t                signal;
    logic                          window_full;

    modport source (output valid, output average, output signal, output window_full,
                    input ready);
    modport sink   (input valid, input average, input signal, input window_full,
                    output ready);
endinterface

// ===== rtl/core/mats_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Divides the running sum by the sample count; depends on mats_pkg.
module mats_div #(
    parameter int SUM_W = 37
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [SUM_W-1:0]             dividend,
    input  logic [mats_pkg::CNT_W-1:0]   divisor,
    output logic                         done,
    output logic [mats_pkg::AVG_W-1:0]   quotient,
    output logic                         rem_zero
);
    import mats_pkg::*;

    localparam int CW = $clog2(SUM_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [SUM_W-1:0]    dvd_reg, dvd_next;
    logic [CNT_W-1:0]    dsr_reg, dsr_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [AVG_W-1:0]    quo_reg, quo_next;
    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      diff;
    logic                fits;

    // Trial subtract of the divisor from the partial remainder
    assign trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(SUM_W - 1);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
            rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next = {quo_reg[AVG_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

// ===== rtl/core/moving_average_trade_signal_unit.sv =====
// Top level of the moving-average trade signal unit.
// Depends on mats_pkg, mats_sample_if / mats_result_if and mats_div.
//
// Usage:
//   sample_ch carries one Q16.16 price per transaction. result_ch returns one
//   transaction per sample: the mean of the last min(count, window) samples
//   (truncated), a buy/sell/hold signal from an exact price*count vs. sum
//   compare, and a window-full flag.
//   cfg_we/cfg_wdata write window_length (0 acts as 1, values above the ring
//   depth act as the depth); a write clears the history. Write only when idle.
// Timing:
//   One sample at a time: a new sample is accepted only once the previous
//   result has been loaded into the output register. Each result waits on
//   the bit-serial divider, which retires one quotient bit per cycle over the
//   SUM_W-bit running sum.
// Reset:
//   History cleared, window_length = 20, no result pending.
// Stall:
//   The result sits in an output register; a new sample is accepted and
//   processed meanwhile, and the finished one waits until the register frees.
module moving_average_trade_signal_unit #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    mats_sample_if.sink                 sample_ch,
    mats_result_if.source               result_ch,
    input  logic                        cfg_we,
    input  logic [mats_pkg::CNT_W-1:0]  cfg_wdata
);
    import mats_pkg::*;

    // Ring depth is bounded by what the 6-bit window register can select
    localparam int WIN_LIM = (1 << CNT_W) - 1;
    localparam int EFF_MAX = (MAX_WINDOW < WIN_LIM) ? MAX_WINDOW : WIN_LIM;
    localparam int AW      = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
    localparam int SUM_W   = PRICE_W + $clog2(EFF_MAX);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUB  = 5'b00010,
        S_ADD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    window_reg;
    logic [AW-1:0]       pos_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [PRICE_W-1:0]  price_reg;
    logic                item_full_reg;
    logic [PRICE_W-1:0]  old_reg;
    logic [PRICE_W-1:0]  ring_mem [EFF_MAX];

    logic                out_valid_reg;
    logic [AVG_W-1:0]    avg_reg;
    sig_t                sig_reg;
    logic                out_full_reg;

    logic [CNT_W-1:0]    win_eff;
    logic                hist_full;
    logic [CNT_W-1:0]    fill_next;
    logic [CNT_W-1:0]    pos_inc;
    logic [SUM_W-1:0]    sum_add;
    logic                accept;
    logic                ring_we;
    logic                out_load;
    logic                div_done;
    logic [AVG_W-1:0]    div_quo;
    logic                div_rem_zero;
    sig_t                sig_calc;

    // Effective window: zero acts as one, clamp to the ring depth
    always_comb
    begin
        priority if (window_reg == '0)
            win_eff = CNT_W'(1);
        else if (int'(window_reg) > EFF_MAX)
            win_eff = CNT_W'(EFF_MAX);
        else
            win_eff = window_reg;
    end

    assign hist_full = (fill_reg >= win_eff);
    assign fill_next = hist_full ? win_eff : fill_reg + 1'b1;
    assign pos_inc   = CNT_W'(pos_reg) + 1'b1;
    assign sum_add   = sum_reg + SUM_W'(price_reg);
    assign accept    = sample_ch.valid && sample_ch.ready;
    assign ring_we   = (state_reg == S_ADD);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || result_ch.ready);

    // Sample ring: one write port, registered read at the current slot
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[pos_reg] <= price_reg;
        old_reg <= ring_mem[pos_reg];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_SUB;
            S_SUB:  state_next = S_ADD;
            S_ADD:  state_next = S_DIV;
            S_DIV:  if (div_done) state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // History state and sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            window_reg <= WINDOW_RESET;
            pos_reg    <= '0;
            fill_reg   <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
                pos_reg    <= '0;
                fill_reg   <= '0;
                sum_reg    <= '0;
            end
            else if (state_reg == S_SUB)
            begin
                // drop the oldest sample once the window is full
                if (hist_full)
                    sum_reg <= sum_reg - SUM_W'(old_reg);
            end
            else if (state_reg == S_ADD)
            begin
                sum_reg  <= sum_add;
                fill_reg <= fill_next;
                pos_reg  <= (pos_inc >= win_eff) ? '0 : AW'(pos_inc);
            end
        end
    end

    // Per-item payload
    always_ff @(posedge clk)
    begin
        if (accept)
            price_reg <= sample_ch.price;
        if (state_reg == S_ADD)
            item_full_reg <= (fill_next >= win_eff);
    end

    // sum = q*count + r with r < count, so price vs. q decides the compare
    always_comb
    begin
        priority if (price_reg > div_quo)
            sig_calc = SIG_BUY;
        else if (price_reg < div_quo || !div_rem_zero)
            sig_calc = SIG_SELL;
        else
            sig_calc = SIG_HOLD;
    end

    mats_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_ADD),
        .dividend (sum_add),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (div_quo),
        .rem_zero (div_rem_zero)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (result_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            avg_reg      <= div_quo;
            sig_reg      <= sig_calc;
            out_full_reg <= item_full_reg;
        end
    end

    assign sample_ch.ready       = (state_reg == S_IDLE);
    assign result_ch.valid       = out_valid_reg;
    assign result_ch.average     = avg_reg;
    assign result_ch.signal      = sig_reg;
    assign result_ch.window_full = out_full_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= win_eff)
        else $error("fill count beyond window");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(pos_reg) < win_eff)
        else $error("write position beyond window");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared without a finished item");

endmodule
